>>> rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared widths, microcode types and the reciprocal table of the cosine
// series engine.
// ----------------------------------------------------------------------------
package cts_pkg;

   localparam int ANGLE_W   = 18;
   localparam int COS_W     = 18;
   localparam int TDATA_W   = 24;
   localparam int TERM_W    = 5;
   localparam int MAX_TERMS = 16;
   localparam int TERM_RST  = 8;

   localparam int MAG_W     = 18;          // |angle|, Q3.14
   localparam int X2_W      = 27;          // x^2, Q.20
   localparam int T_W       = 34;          // term magnitude, Q.24
   localparam int P_W       = 40;          // term * x^2, Q.24
   localparam int ACC_W     = 26;          // signed partial sum, Q.24
   localparam int ADD_W     = 36;          // acc +/- t before clamping
   localparam int MA_W      = 24;          // multiplier operand A (one chunk)
   localparam int MB_W      = 28;          // multiplier operand B
   localparam int MP_W      = MA_W + MB_W;
   localparam int SUM_W     = 64;          // chunk recombination
   localparam int RECIP_W   = 24;
   localparam int CHUNK     = 24;
   localparam int FRAC_T    = 24;

   localparam int PC_W      = 4;

   localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1 << FRAC_T);
   localparam logic signed [ADD_W-1:0] ACC_MAX = ADD_W'((1 << 25) - 1);
   localparam logic signed [ADD_W-1:0] ACC_MIN = -ADD_W'(1 << 25);

   typedef enum logic [2:0] {
      MA_MAG,
      MA_T_LO,
      MA_T_HI,
      MA_P_LO,
      MA_P_HI
   } mul_a_type;

   typedef enum logic [1:0] {
      MB_MAG,
      MB_X2,
      MB_RECIP
   } mul_b_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_INIT,     // t = 1.0, acc = 1.0
      OP_X2,       // x2 = round(mag^2 / 2^8)
      OP_LDP,      // hold low partial product
      OP_P,        // p = round(t * x2 / 2^20)
      OP_T,        // t = round(p * R / 2^24)
      OP_ACC       // acc = clamp(acc -/+ t)
   } dp_op_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_NO_TERMS,
      JMP_MORE,
      JMP_END
   } jump_type;

   typedef struct packed {
      logic                mul_en;
      mul_a_type           mul_a;
      mul_b_type           mul_b;
      dp_op_type           op;
      jump_type            jmp;
      logic [PC_W-1:0]     target;
   } ucode_type;

   typedef struct packed {
      logic                en;
      logic                mul_en;
      mul_a_type           mul_a;
      mul_b_type           mul_b;
      dp_op_type           op;
      logic [TERM_W-1:0]   j;
   } ctrl_type;

   localparam logic [PC_W-1:0] PC_LOOP = PC_W'(2);
   localparam logic [PC_W-1:0] PC_FIN  = PC_W'(9);

   // round(2^24 / ((2j-1)(2j))), half up
   function automatic logic [RECIP_W-1:0] recip_rom(input logic [TERM_W-1:0] j);
      logic [RECIP_W-1:0] r;
      case (j)
         5'd1:    r = 24'd8388608;
         5'd2:    r = 24'd1398101;
         5'd3:    r = 24'd559241;
         5'd4:    r = 24'd299593;
         5'd5:    r = 24'd186414;
         5'd6:    r = 24'd127100;
         5'd7:    r = 24'd92183;
         5'd8:    r = 24'd69905;
         5'd9:    r = 24'd54828;
         5'd10:   r = 24'd44151;
         5'd11:   r = 24'd36314;
         5'd12:   r = 24'd30394;
         5'd13:   r = 24'd25811;
         5'd14:   r = 24'd22192;
         5'd15:   r = 24'd19284;
         5'd16:   r = 24'd16913;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/cosine_taylor_series.sv
// ----------------------------------------------------------------------------
// cosine_taylor_series
// Fixed-point cosine by Maclaurin series, one angle per transaction.
//
// req_*: angle in signed Q3.14 in req_tdata[17:0], req_tlast passes through.
// rsp_*: cosine in signed Q2.16 in rsp_tdata[17:0], saturated; rsp_tlast is
//        the req_tlast of the same transaction.
// csr_*: term_count (0..16 used, larger values act as 16), reset value 8.
//        Write it only while the block is idle.
// Each angle runs a microcode program on one shared 24x28 multiplier; every
// term needs four chunk products, two recombinations and one add. One angle
// is worked at a time, and the next is accepted only once the result has
// loaded and the engine is idle again. req_tready is high whenever the
// engine is idle, also while a result waits in the output register. If
// rsp_tready stays low, the engine holds its next result on the final step
// until the output register drains.
// Synchronous reset empties the engine and the output register and sets
// term_count back to 8.
// ----------------------------------------------------------------------------
module cosine_taylor_series (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,   // [17:0] angle
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,   // [17:0] cosine
   output logic                        rsp_tlast,
   input  logic                        csr_wr_en,
   input  logic [4:0]                  csr_wr_data  // term_count
);
   import cts_pkg::*;

   logic [TERM_W-1:0] term_count_ff, term_count_in;
   logic              last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COS_W-1:0]  rsp_cos_ff;
   logic              rsp_last_ff;
   logic              req_fire;
   logic              hold;
   logic              seq_busy;
   logic              seq_done;
   logic [COS_W-1:0]  cosine;
   ctrl_type          ctrl;

   assign req_tready = !seq_busy;
   assign req_fire   = req_tvalid && req_tready;
   assign hold       = rsp_valid_ff && !rsp_tready;

   assign term_count_in = csr_wr_en ? csr_wr_data : term_count_ff;

   cts_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_fire),
      .hold       (hold),
      .term_count (term_count_ff),
      .ctrl       (ctrl),
      .busy       (seq_busy),
      .done       (seq_done)
   );

   cts_datapath u_dp (
      .clock  (clock),
      .load   (req_fire),
      .angle  (req_tdata[ANGLE_W-1:0]),
      .ctrl   (ctrl),
      .cosine (cosine)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_done)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TERM_W'(TERM_RST);
         rsp_valid_ff  <= 1'b0;
      end else begin
         term_count_ff <= term_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) last_ff <= req_tlast;
      if (seq_done) begin
         rsp_cos_ff  <= cosine;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(TDATA_W-COS_W)'(0), rsp_cos_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a new transaction starts the engine, which then refuses input
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> seq_busy)
      else $error("engine not busy after accepting a transaction");

   // the engine only starts on an accepted transaction
   a_busy_source: assert property (@(posedge clock) disable iff (reset)
      $rose(seq_busy) |-> $past(req_fire))
      else $error("engine started without a transaction");

   // a result is only loaded when the output register is free or draining
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrote a pending response");

   // every finished item clears the engine on the next edge
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      seq_done |=> !seq_busy)
      else $error("engine still busy after finishing");

endmodule

>>> rtl/cts_sequencer.sv
// ----------------------------------------------------------------------------
// cts_sequencer
// Microcode ROM, program counter and term counter of the cosine engine.
// ----------------------------------------------------------------------------
module cts_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      hold,
   input  logic [cts_pkg::TERM_W-1:0] term_count,
   output cts_pkg::ctrl_type         ctrl,
   output logic                      busy,
   output logic                      done
);
   import cts_pkg::*;

   logic                busy_ff, busy_in;
   logic [PC_W-1:0]     pc_ff, pc_in;
   logic [TERM_W-1:0]   j_ff, j_in;
   logic [TERM_W-1:0]   n_terms;
   logic [PC_W-1:0]     pc_next;
   ucode_type           uw;

   assign n_terms = (term_count > TERM_W'(MAX_TERMS)) ? TERM_W'(MAX_TERMS) : term_count;

   // program: 0-1 setup, 2-8 one series term, 9 finish
   always_comb begin
      uw = '{mul_en: 1'b0, mul_a: MA_MAG, mul_b: MB_MAG, op: OP_NOP,
             jmp: JMP_NONE, target: '0};
      unique case (pc_ff)
         4'd0: uw = '{1'b1, MA_MAG,  MB_MAG,   OP_INIT, JMP_NONE,     '0};
         4'd1: uw = '{1'b0, MA_MAG,  MB_MAG,   OP_X2,   JMP_NO_TERMS, PC_FIN};
         4'd2: uw = '{1'b1, MA_T_LO, MB_X2,    OP_NOP,  JMP_NONE,     '0};
         4'd3: uw = '{1'b1, MA_T_HI, MB_X2,    OP_LDP,  JMP_NONE,     '0};
         4'd4: uw = '{1'b0, MA_MAG,  MB_MAG,   OP_P,    JMP_NONE,     '0};
         4'd5: uw = '{1'b1, MA_P_LO, MB_RECIP, OP_NOP,  JMP_NONE,     '0};
         4'd6: uw = '{1'b1, MA_P_HI, MB_RECIP, OP_LDP,  JMP_NONE,     '0};
         4'd7: uw = '{1'b0, MA_MAG,  MB_MAG,   OP_T,    JMP_NONE,     '0};
         4'd8: uw = '{1'b0, MA_MAG,  MB_MAG,   OP_ACC,  JMP_MORE,     PC_LOOP};
         4'd9: uw = '{1'b0, MA_MAG,  MB_MAG,   OP_NOP,  JMP_END,      '0};
         default: ;
      endcase
   end

   always_comb begin
      pc_next = pc_ff + PC_W'(1);
      unique case (uw.jmp)
         JMP_NONE:     pc_next = pc_ff + PC_W'(1);
         JMP_NO_TERMS: if (n_terms == '0) pc_next = uw.target;
         JMP_MORE:     if (j_ff < n_terms) pc_next = uw.target;
         JMP_END:      pc_next = hold ? pc_ff : '0;
         default:      ;
      endcase
   end

   assign done = busy_ff && (uw.jmp == JMP_END) && !hold;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      j_in    = j_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = '0;
            j_in    = TERM_W'(1);
         end
      end else begin
         pc_in = pc_next;
         if (uw.op == OP_ACC) j_in = j_ff + TERM_W'(1);
         if (done) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
         j_ff    <= TERM_W'(1);
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         j_ff    <= j_in;
      end
   end

   assign busy        = busy_ff;
   assign ctrl.en     = busy_ff;
   assign ctrl.mul_en = uw.mul_en;
   assign ctrl.mul_a  = uw.mul_a;
   assign ctrl.mul_b  = uw.mul_b;
   assign ctrl.op     = uw.op;
   assign ctrl.j      = j_ff;

endmodule

>>> rtl/cts_datapath.sv
// ----------------------------------------------------------------------------
// cts_datapath
// Shared 24x28 multiplier, term and sum registers, output rounding.
// ----------------------------------------------------------------------------
module cts_datapath (
   input  logic                        clock,
   input  logic                        load,
   input  logic [cts_pkg::ANGLE_W-1:0] angle,
   input  cts_pkg::ctrl_type           ctrl,
   output logic [cts_pkg::COS_W-1:0]   cosine
);
   import cts_pkg::*;

   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [MP_W-1:0]         mp_ff, mp_in;
   logic [MP_W-1:0]         pacc_ff;
   logic [X2_W-1:0]         x2_ff;
   logic [T_W-1:0]          t_ff;
   logic [P_W-1:0]          p_ff;
   logic signed [ACC_W-1:0] acc_ff;

   logic [MA_W-1:0]         op_a;
   logic [MB_W-1:0]         op_b;
   logic [SUM_W-1:0]        sum;
   logic [SUM_W-1:0]        sum_p, sum_t;
   logic signed [ADD_W-1:0] acc_ext, t_ext, acc_raw;
   logic signed [ACC_W-1:0] acc_clamped;
   logic [ACC_W-1:0]        acc_bias;
   logic [ACC_W:0]          out_rnd;
   logic [COS_W:0]          out_r;
   logic [COS_W-1:0]        out_sat;

   // cosine is even: keep only |angle|
   assign mag_in = angle[ANGLE_W-1] ? MAG_W'(~angle + ANGLE_W'(1)) : MAG_W'(angle);

   always_comb begin
      case (ctrl.mul_a)
         MA_MAG:  op_a = MA_W'(mag_ff);
         MA_T_LO: op_a = t_ff[CHUNK-1:0];
         MA_T_HI: op_a = MA_W'(t_ff[T_W-1:CHUNK]);
         MA_P_LO: op_a = p_ff[CHUNK-1:0];
         MA_P_HI: op_a = MA_W'(p_ff[P_W-1:CHUNK]);
         default: op_a = '0;
      endcase
      case (ctrl.mul_b)
         MB_MAG:   op_b = MB_W'(mag_ff);
         MB_X2:    op_b = MB_W'(x2_ff);
         MB_RECIP: op_b = MB_W'(recip_rom(ctrl.j));
         default:  op_b = '0;
      endcase
   end

   assign mp_in = MP_W'(op_a) * MP_W'(op_b);

   // low chunk product plus high chunk product shifted into place
   assign sum   = SUM_W'(pacc_ff) + (SUM_W'(mp_ff) << CHUNK);
   assign sum_p = sum + (SUM_W'(1) << 19);
   assign sum_t = sum + (SUM_W'(1) << (FRAC_T - 1));

   assign acc_ext = ADD_W'(acc_ff);
   assign t_ext   = $signed(ADD_W'(t_ff));
   assign acc_raw = ctrl.j[0] ? (acc_ext - t_ext) : (acc_ext + t_ext);
   assign acc_clamped = (acc_raw > ACC_MAX) ? ACC_W'(ACC_MAX) :
                        (acc_raw < ACC_MIN) ? ACC_W'(ACC_MIN) : ACC_W'(acc_raw);

   always_ff @(posedge clock) begin
      if (load) mag_ff <= mag_in;
      if (ctrl.en) begin
         if (ctrl.mul_en) mp_ff <= mp_in;
         case (ctrl.op)
            OP_INIT: begin
               t_ff   <= T_W'(1) << FRAC_T;
               acc_ff <= ACC_ONE;
            end
            OP_X2:   x2_ff   <= X2_W'((mp_ff[2*MAG_W-1:0] + (2*MAG_W)'(128)) >> 8);
            OP_LDP:  pacc_ff <= mp_ff;
            OP_P:    p_ff    <= sum_p[P_W+19:20];
            OP_T:    t_ff    <= sum_t[T_W+FRAC_T-1:FRAC_T];
            OP_ACC:  acc_ff  <= acc_clamped;
            default: ;
         endcase
      end
   end

   // Q.24 sum -> Q2.16: bias to unsigned, round half up, clamp, unbias
   assign acc_bias = {~acc_ff[ACC_W-1], acc_ff[ACC_W-2:0]};
   assign out_rnd  = (ACC_W+1)'(acc_bias) + (ACC_W+1)'(128);
   assign out_r    = out_rnd[ACC_W:8];
   assign out_sat  = out_r[COS_W] ? {COS_W{1'b1}} : out_r[COS_W-1:0];
   assign cosine   = {~out_sat[COS_W-1], out_sat[COS_W-2:0]};

endmodule

>>> verif/cts_checker.sv
// ----------------------------------------------------------------------------
// cts_checker
// Watches the request, response and CSR ports of cosine_taylor_series.
// Predicts the saturated series cosine of every accepted angle, queues it,
// and compares each response transaction against the oldest queued value.
// ----------------------------------------------------------------------------
module cts_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,     // [17:0] angle
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,     // [17:0] cosine
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,   // term_count
   output int          fail_count,
   output int          pending,
   output int          checked
);
   import cts_pkg::*;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic [TERM_W-1:0]         terms;
      logic signed [COS_W-1:0]   cosine;
      logic                      last;
   } cos_entry_type;

   cos_entry_type     cos_expected_q[$];
   logic [TERM_W-1:0] term_count = TERM_W'(TERM_RST);
   int                errors;
   int                n_checked;

   // Magnitude-and-sign evaluation: x^2 in Q.20, term in Q.24, sum in Q.24
   function automatic logic signed [COS_W-1:0] series_cosine(
      input logic signed [ANGLE_W-1:0] angle,
      input logic [TERM_W-1:0]         terms
   );
      longint          a;
      longint unsigned mag, x2, t, p, div, recip, u, r;
      longint          acc;
      int              n;
      a   = angle;
      mag = (a < 0) ? longint'(-a) : longint'(a);
      x2  = (mag * mag + 64'd128) >> 8;
      n   = (terms > MAX_TERMS) ? MAX_TERMS : int'(terms);
      t   = 64'd1 << 24;
      acc = longint'(1) << 24;
      for (int j = 1; j <= n; j++) begin
         p     = (t * x2 + (64'd1 << 19)) >> 20;
         div   = longint'(2 * j - 1) * longint'(2 * j);
         recip = ((64'd1 << 24) + div / 2) / div;
         t     = (p * recip + (64'd1 << 23)) >> 24;
         acc   = (j % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
         if (acc > (longint'(1) << 25) - 1)
            acc = (longint'(1) << 25) - 1;
         else if (acc < -(longint'(1) << 25))
            acc = -(longint'(1) << 25);
      end
      u = longint'(acc + (longint'(1) << 25));
      r = (u + 64'd128) >> 8;
      if (r > 64'h3FFFF)
         r = 64'h3FFFF;
      return COS_W'(r - 64'h20000);
   endfunction

   always @(posedge clock) begin
      cos_entry_type want;
      cos_entry_type fresh;
      if (reset) begin
         term_count = TERM_W'(TERM_RST);
      end else begin
         if (csr_wr_en)
            term_count = csr_wr_data;
         // response first so a same-cycle request never pairs with it
         if (rsp_tvalid && rsp_tready) begin
            if (cos_expected_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected response: cosine %0d last %0b",
                           $signed(rsp_tdata[COS_W-1:0]), rsp_tlast);
            end else begin
               want = cos_expected_q.pop_front();
               n_checked++;
               if (want.cosine !== rsp_tdata[COS_W-1:0] || want.last !== rsp_tlast) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: angle %0d terms %0d expected cosine %0d ",
                               "last %0b, got cosine %0d last %0b"},
                              want.angle, want.terms, want.cosine, want.last,
                              $signed(rsp_tdata[COS_W-1:0]), rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            fresh.angle  = req_tdata[ANGLE_W-1:0];
            fresh.terms  = term_count;
            fresh.cosine = series_cosine(req_tdata[ANGLE_W-1:0], term_count);
            fresh.last   = req_tlast;
            cos_expected_q.push_back(fresh);
         end
      end
      fail_count <= errors;
      pending    <= cos_expected_q.size();
      checked    <= n_checked;
   end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for cosine_taylor_series. Sends directed angles at
// range limits, multiples of pi and saturating term counts, then random
// angles over several term_count settings with random stalls on both ports
// in all phases but one. Prediction and comparison live in cts_checker.
// ----------------------------------------------------------------------------
module tb_top;
   import cts_pkg::*;

   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 130;     // over one full 16-term angle
   localparam int LIMIT_CYCLES  = 600000;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 100;

   localparam logic signed [ANGLE_W-1:0] ANG_MAX = 18'sd131071;
   localparam logic signed [ANGLE_W-1:0] ANG_MIN = -18'sd131072;
   localparam logic signed [ANGLE_W-1:0] ANG_ONE = 18'sd16384;
   localparam logic signed [ANGLE_W-1:0] HALF_PI = 18'sd25736;
   localparam logic signed [ANGLE_W-1:0] ANG_PI  = 18'sd51472;
   localparam logic signed [ANGLE_W-1:0] TWO_PI  = 18'sd102944;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [4:0]  csr_wr_data = '0;

   logic        req_fire    = 1'b0;
   int          fail_count;
   int          pending_count;
   int          checked_count;
   int          req_idle_pct = 25;
   int          rsp_idle_pct = 25;
   int          n_settings   = 1;      // reset value counts as one
   int          last_marks   = 0;

   cosine_taylor_series uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   cts_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending_count),
      .checked     (checked_count)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("[cosine_taylor_series] ERROR");
      $finish;
   end

   // registered handshake, read back at the falling edge
   always @(posedge clock)
      req_fire <= req_tvalid && req_tready;

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_angle(input logic signed [ANGLE_W-1:0] angle, input logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, angle};
      req_tlast  <= last;
      if (last)
         last_marks++;
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   task automatic set_terms(input int terms);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= TERM_W'(terms);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      n_settings++;
   endtask

   initial begin
      int                        terms;
      int                        pick;
      int                        v;
      logic signed [ANGLE_W-1:0] angle;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset term count (8)
      send_angle(18'sd0, 1'b0);
      send_angle(18'sd1, 1'b0);
      send_angle(-18'sd1, 1'b0);
      send_angle(ANG_MAX, 1'b0);
      send_angle(ANG_MIN, 1'b0);
      send_angle(HALF_PI, 1'b0);
      send_angle(ANG_PI, 1'b0);
      send_angle(-ANG_PI, 1'b0);
      send_angle(TWO_PI, 1'b0);
      send_angle(ANG_ONE, 1'b0);
      send_angle(-ANG_ONE, 1'b1);
      // no terms: always 1.0
      set_terms(0);
      send_angle(18'sd12345, 1'b0);
      send_angle(ANG_MIN, 1'b1);
      // full series
      set_terms(MAX_TERMS);
      send_angle(ANG_MIN, 1'b0);
      send_angle(ANG_MAX, 1'b0);
      send_angle(ANG_PI, 1'b0);
      send_angle(18'sd0, 1'b1);
      // above the table size, acts as 16
      set_terms(31);
      send_angle(ANG_MIN, 1'b0);
      send_angle(TWO_PI, 1'b1);
      // partial sum clamps low, then high with output saturation
      set_terms(1);
      send_angle(ANG_MAX, 1'b0);
      send_angle(ANG_ONE, 1'b1);
      set_terms(2);
      send_angle(ANG_MAX, 1'b0);
      send_angle(ANG_MIN, 1'b1);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       terms = 4;
            1:       terms = MAX_TERMS;
            2:       terms = 12;
            3:       terms = $urandom_range(0, 31);
            4:       terms = 0;
            default: terms = 31;
         endcase
         set_terms(terms);
         // one phase runs with no stalls on either side
         req_idle_pct = (ph == 2) ? 0 : 25;
         rsp_idle_pct = (ph == 2) ? 0 : 25;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 1 && k == PHASE_ITEMS / 2)
               wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               v = $urandom_range(0, 262143);
            end else if (pick < 85) begin
               v = $urandom_range(0, 2 * int'(TWO_PI)) - int'(TWO_PI);
            end else begin
               case ($urandom_range(0, 3))
                  0:       v = int'(ANG_MAX);
                  1:       v = int'(ANG_MIN);
                  2:       v = int'(ANG_MAX) - $urandom_range(0, 255);
                  default: v = $urandom_range(0, 511) - 256;
               endcase
            end
            angle = ANGLE_W'(v);
            send_angle(angle, $urandom_range(0, 7) == 0);
         end
      end

      wait_drained();
      repeat (END_CYCLES) @(negedge clock);

      $display("covered %0d angles over %0d term_count settings (0, 1, 2, 16, 31 and others)",
               checked_count, n_settings);
      $display("range limits, multiples of pi, clamped partial sums, %0d tlast marks",
               last_marks);
      if (fail_count == 0 && pending_count == 0)
         $display("[cosine_taylor_series] OK");
      else
         $display("[cosine_taylor_series] ERROR");
      $finish;
   end

endmodule
